### hdl/b2d_pkg.sv
// Shared definitions for the binary to decimal ASCII converter.
// Holds the sizing constants, the control struct of the digit cells and the
// BCD adjust function. No dependencies.
package b2d_pkg;

  // Width of the binary value that takes part in the conversion (4 to 64).
  localparam int VALUE_WIDTH = 64;

  // Each cell applies this many shift-and-adjust steps per clock.
  localparam int BITS_PER_STEP = 4;
  localparam int STEPS         = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int PAD_W         = STEPS * BITS_PER_STEP;

  // Decimal digits needed for the largest value: floor(W * log10(2)) + 1.
  localparam int NUM_DIGITS    = ((VALUE_WIDTH * 1233) >> 12) + 1;

  localparam int STEP_CNT_W    = $clog2(STEPS + 1);
  localparam int REM_CNT_W     = $clog2(NUM_DIGITS + 1);

  localparam logic [5:0] ASCII_ZERO = 6'd48;

  typedef struct packed {
    logic clear;   // start of a new request: empty the digit
    logic dabble;  // conversion: take BITS_PER_STEP bits from below
    logic shift;   // readout: take the digit of the cell below
  } cell_ctrl_t;

  // Add three to a BCD digit of five or more, ahead of the shift.
  function automatic logic [3:0] bcd_adjust(input logic [3:0] d);
    bcd_adjust = (d >= 4'd5) ? (d + 4'd3) : d;
  endfunction

endpackage

### hdl/binary_to_decimal_ascii.sv
// Binary to decimal ASCII converter, top level.
// Depends on b2d_pkg and instantiates a chain of b2d_cell digit cells.
//
// Usage: one request on the in_ channel carries an unsigned binary value.
// The block answers with one out_ request per decimal digit, most
// significant digit first, as an ASCII code '0'..'9'. Leading zeros are
// dropped; zero gives the single character '0'. out_last marks the final
// digit of the number.
// Timing: after a request is taken the value is shifted into the digit
// chain four bits a clock. Readout then moves the chain up by one digit a
// clock, for each dropped leading zero and for each digit; a digit waits
// while the receiver stalls.
// in_ready is high only while no number is in progress. The final digit
// sits in an output register, so the next request is taken while it waits.
// A stalled receiver holds out_valid and the payload and pauses readout.
// Reset (rst_n low, synchronous) drops any number in progress.
module binary_to_decimal_ascii
  import b2d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_digit_char,
  output logic        out_last
);

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_EMIT} state_t;

  state_t                  state_r;
  logic [PAD_W-1:0]        val_r;
  logic [STEP_CNT_W-1:0]   step_r;
  logic [REM_CNT_W-1:0]    rem_r;
  logic                    seen_r;
  logic                    out_valid_r;
  logic [5:0]              out_char_r;
  logic                    out_last_r;

  cell_ctrl_t              ctrl;
  logic [BITS_PER_STEP-1:0] bits_w  [NUM_DIGITS];
  logic [3:0]              digit_w [NUM_DIGITS];
  logic [3:0]              top_d;
  logic                    skip;
  logic                    emit_go;
  logic                    in_take;

  assign in_ready = (state_r == S_IDLE);
  assign in_take  = in_valid && in_ready;

  assign top_d   = digit_w[NUM_DIGITS-1];
  // Leading zeros are passed over, but the units digit is always sent.
  assign skip    = (state_r == S_EMIT) && (top_d == 4'd0) && !seen_r &&
                   (rem_r != REM_CNT_W'(1));
  assign emit_go = (state_r == S_EMIT) && !skip && (!out_valid_r || out_ready);

  always_comb begin
    ctrl.clear  = in_take;
    ctrl.dabble = (state_r == S_CONV);
    ctrl.shift  = skip || emit_go;
  end

  assign bits_w[0] = val_r[PAD_W-1 -: BITS_PER_STEP];

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    logic [3:0] below_d;
    if (i == 0) begin : g_bot
      assign below_d = 4'd0;
    end else begin : g_mid
      assign below_d = digit_w[i-1];
    end
    if (i == NUM_DIGITS - 1) begin : g_top
      b2d_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .bits_in   (bits_w[i]),
        .digit_in  (below_d),
        .bits_out  (),
        .digit_out (digit_w[i])
      );
    end else begin : g_chain
      b2d_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .bits_in   (bits_w[i]),
        .digit_in  (below_d),
        .bits_out  (bits_w[i+1]),
        .digit_out (digit_w[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      rem_r       <= '0;
      seen_r      <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            val_r   <= PAD_W'(in_value[VALUE_WIDTH-1:0]);
            step_r  <= '0;
            state_r <= S_CONV;
          end
        end
        S_CONV: begin
          val_r  <= val_r << BITS_PER_STEP;
          step_r <= step_r + STEP_CNT_W'(1);
          if (step_r == STEP_CNT_W'(STEPS - 1)) begin
            rem_r   <= REM_CNT_W'(NUM_DIGITS);
            seen_r  <= 1'b0;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (skip) begin
            rem_r <= rem_r - REM_CNT_W'(1);
          end else if (emit_go) begin
            out_char_r  <= ASCII_ZERO + {2'b00, top_d};
            out_last_r  <= (rem_r == REM_CNT_W'(1));
            seen_r      <= 1'b1;
            rem_r       <= rem_r - REM_CNT_W'(1);
            if (rem_r == REM_CNT_W'(1)) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last       = out_last_r;

endmodule

### hdl/b2d_cell.sv
// One BCD digit cell of the double-dabble chain.
// Depends on b2d_pkg for the control struct and the adjust function.
module b2d_cell
  import b2d_pkg::*;
(
  input  logic                     clk,
  input  cell_ctrl_t               ctrl,
  input  logic [BITS_PER_STEP-1:0] bits_in,
  input  logic [3:0]               digit_in,
  output logic [BITS_PER_STEP-1:0] bits_out,
  output logic [3:0]               digit_out
);

  logic [3:0] digit_r;
  logic [3:0] dabble_d;

  // Bits arrive most significant first: bits_in[BITS_PER_STEP-1] goes in first.
  always_comb begin
    logic [3:0] a;
    dabble_d = digit_r;
    bits_out = '0;
    for (int j = BITS_PER_STEP - 1; j >= 0; j--) begin
      a           = bcd_adjust(dabble_d);
      bits_out[j] = a[3];
      dabble_d    = {a[2:0], bits_in[j]};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit_r <= 4'd0;
    end else if (ctrl.dabble) begin
      digit_r <= dabble_d;
    end else if (ctrl.shift) begin
      digit_r <= digit_in;
    end
  end

  assign digit_out = digit_r;

endmodule

### sim/tb.sv
// Testbench for binary_to_decimal_ascii: drives unsigned values and checks
// every digit character and last flag against a predictor in the scoreboard.
// Depends on b2d_pkg and the binary_to_decimal_ascii RTL.
module tb;
  import b2d_pkg::*;

  localparam int          RUN_LIMIT   = 400000;
  localparam int          RAND_ITEMS  = 225;
  localparam int          HOLD_CYCLES = 300;
  localparam logic [63:0] VALUE_MASK  = {64{1'b1}} >> (64 - VALUE_WIDTH);

  typedef struct packed {
    logic [5:0] ch;
    logic       last;
  } digit_t;

  class digit_scoreboard;
    digit_t expected_digits[$];
    int     errors;
    int     numbers_seen;
    int     digits_seen;
    int     longest;

    function new();
      errors       = 0;
      numbers_seen = 0;
      digits_seen  = 0;
      longest      = 0;
    endfunction

    task report(string what);
      if (errors < 50) $display("mismatch: %s", what);
      errors++;
    endtask

    // Decimal expansion of one accepted request, most significant digit first.
    function void note_value(logic [63:0] value);
      logic [63:0] v;
      digit_t      d;
      digit_t      text[$];
      v = value & VALUE_MASK;
      do begin
        d.ch   = ASCII_ZERO + 6'(v % 64'd10);
        d.last = 1'b0;
        text.push_front(d);
        v = v / 64'd10;
      end while (v != 64'd0);
      text[text.size() - 1].last = 1'b1;
      if (text.size() > longest) longest = text.size();
      foreach (text[i]) expected_digits.push_back(text[i]);
      numbers_seen++;
    endfunction

    task check_digit(logic [5:0] ch, logic last);
      digit_t want;
      digits_seen++;
      if (expected_digits.size() == 0) begin
        report($sformatf("unexpected digit %0d last %0b", ch, last));
      end else begin
        want = expected_digits.pop_front();
        if (ch !== want.ch)
          report($sformatf("digit_char %0d, expected %0d", ch, want.ch));
        if (last !== want.last)
          report($sformatf("last %0b, expected %0b", last, want.last));
      end
    endtask

    function int pending();
      return expected_digits.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_value = 64'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  out_digit_char;
  logic        out_last;

  digit_scoreboard sb = new();
  int  cycles      = 0;
  int  n_accepted  = 0;
  int  stall_left  = 0;
  bit  quiet       = 1'b0;   // no random gaps on either side while set
  bit  hold_off    = 1'b0;

  binary_to_decimal_ascii dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digit_char (out_digit_char),
    .out_last       (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb failed");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task send_value(logic [63:0] v);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_value(v);
    n_accepted++;
    @(negedge clk);
  endtask

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    logic [63:0] p;
    int          len;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: begin
        // Right at a decimal boundary: ten to some power, or one below it.
        p = 64'd1;
        repeat ($urandom_range(0, 19)) p = p * 64'd10;
        v = p - 64'($urandom_range(0, 1));
      end
      1: v = v;
      default: begin
        len = $urandom_range(0, 64);
        if (len < 64) v = v & ((64'd1 << len) - 64'd1);
      end
    endcase
    return v;
  endfunction

  // Receiver side: per result a random pause, plus the long hold-off.
  always @(negedge clk) begin
    out_ready <= !(hold_off || (stall_left > 0));
  end

  // The pause is drawn when a result is taken and counted down while it lasts.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_digit(out_digit_char, out_last);
      stall_left = quiet ? 0 : $urandom_range(0, 4);
    end else if (stall_left > 0) begin
      stall_left--;
    end
  end

  // Keep the result side blocked long enough for the input side to stall.
  initial begin
    wait (n_accepted >= 40);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    logic [63:0] directed[$];
    int          drain;

    directed = '{64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100, 64'd12345,
                 64'h0000_0000_FFFF_FFFF, 64'h0000_0001_0000_0000,
                 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                 64'd1000000000000000000, 64'd9999999999999999999,
                 64'd10000000000000000000, 64'h8000_0000_0000_0000,
                 64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF,
                 64'h0123_4567_89AB_CDEF, 64'd7};

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    quiet = 1'b1;
    foreach (directed[i]) send_value(directed[i]);
    quiet = 1'b0;
    foreach (directed[i]) send_value(directed[i]);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 45 == 0) quiet = ($urandom_range(0, 2) == 0);
      send_value(random_value());
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    drain = 0;
    while (drain < 60) begin
      @(posedge clk);
      drain++;
    end
    if (sb.pending() != 0)
      sb.report($sformatf("%0d digits never arrived", sb.pending()));

    $display("converted %0d numbers into %0d digits, longest %0d digits,",
             sb.numbers_seen, sb.digits_seen, sb.longest);
    $display("with random gaps on both sides and one long output stall");
    if (sb.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("tb failed");
    end
    $finish;
  end

endmodule
